>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/cse_pkg.sv
package cse_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_BITS = 24;
  localparam int WIDE_W = 41;

  localparam logic [1:0] REG_COEFF_COUNT = 2'd0;
  localparam logic [1:0] REG_DOMAIN_MID = 2'd1;
  localparam logic [1:0] REG_INV_HALF_WIDTH = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic signed [WIDE_W-1:0] SAT_HI = 41'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -41'sd2147483648;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } sat_res_t;

  function automatic logic signed [WIDE_W-1:0] ext(input logic [DATA_W-1:0] v);
    return {{(WIDE_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic sat_res_t sat_wide(input logic signed [WIDE_W-1:0] v);
    sat_res_t r;
    if (v > SAT_HI) begin
      r.sat = 1'b1;
      r.val = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r.sat = 1'b1;
      r.val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r.sat = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> sv/cse_mul.sv
module cse_mul (
  input  logic                          clk,
  input  logic signed [cse_pkg::DATA_W-1:0] a,
  input  logic signed [cse_pkg::DATA_W-1:0] b,
  output cse_pkg::sat_res_t             res
);

  localparam int PW = 2 * cse_pkg::DATA_W;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // round half up, floor shift, saturate
  always_comb begin
    rnd = prod + (PW'(1) <<< (cse_pkg::FRAC_BITS - 1));
    res = cse_pkg::sat_wide({rnd[PW-1], rnd[PW-1:cse_pkg::FRAC_BITS]});
  end

endmodule

>>> sv/chebyshev_series_eval_core.sv
// Load request: writes the coefficient table when taken, no result.
// Evaluate request: S_OFS, S_MAP, S_RND, one S_LMUL/S_ACC step per clamped
// coefficient beyond two, then S_FMUL; the result is registered in S_FACC once
// the output is free, and the next request is taken only after that. Each step
// uses the shared 32x32 multiplier, then the add/saturate stage.
// Reset (rst, synchronous): idle, no result pending, registers to defaults.
`include "assert_macros.svh"

module chebyshev_series_eval_core #(
  parameter int MAX_COEFFS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [cse_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [$clog2(MAX_COEFFS)-1:0]     coeff_index,
  input  logic signed [cse_pkg::DATA_W-1:0] coeff_value,
  input  logic signed [cse_pkg::DATA_W-1:0] point,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cse_pkg::DATA_W-1:0] value,
  output logic                              saturated
);

  localparam int IW = $clog2(MAX_COEFFS);
  localparam int CW = $clog2(MAX_COEFFS + 1);
  localparam int DW = cse_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE, S_OFS, S_MAP, S_RND, S_LMUL, S_ACC, S_FMUL, S_FACC
  } state_t;

  state_t state;
  logic [CW-1:0] coeff_count;
  logic [DW-1:0] domain_mid;
  logic [DW-1:0] inv_half_width;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] cnt;
  logic [DW-1:0] pt;
  logic [DW-1:0] x;
  logic [DW-1:0] x2;
  logic [DW-1:0] c0;
  logic [DW-1:0] c1;
  logic [DW-1:0] t;
  logic          flag;
  logic [DW-1:0] coeff_mem [MAX_COEFFS];
  logic [DW-1:0] rdata;
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  cse_pkg::sat_res_t mres;
  cse_pkg::sat_res_t d;
  cse_pkg::sat_res_t d2;
  logic          take;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign take      = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (coeff_count < CW'(2)) begin
      n_eff = CW'(2);
    end else if (coeff_count > CW'(MAX_COEFFS)) begin
      n_eff = CW'(MAX_COEFFS);
    end else begin
      n_eff = coeff_count;
    end
  end

  always_ff @(posedge clk) begin
    if (take && op == cse_pkg::OP_LOAD && {1'b0, coeff_index} < (IW+1)'(MAX_COEFFS)) begin
      coeff_mem[coeff_index] <= coeff_value;
    end
    rdata <= coeff_mem[cnt[IW-1:0]];
  end

  always_comb begin
    case (state)
      S_MAP: begin
        mul_a = x;
        mul_b = inv_half_width;
      end
      S_LMUL: begin
        mul_a = c0;
        mul_b = x2;
      end
      default: begin
        mul_a = c0;
        mul_b = x;
      end
    endcase
  end

  cse_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mres)
  );

  always_comb begin
    d  = cse_pkg::sat_wide(cse_pkg::ext(c1) + cse_pkg::ext(mres.val));
    d2 = cse_pkg::sat_wide(cse_pkg::ext(mres.val) <<< 1);
    case (state)
      S_OFS:  d = cse_pkg::sat_wide(cse_pkg::ext(pt) - cse_pkg::ext(domain_mid));
      S_LMUL: d = cse_pkg::sat_wide(cse_pkg::ext(rdata) - cse_pkg::ext(c0));
      S_ACC:  d = cse_pkg::sat_wide(cse_pkg::ext(mres.val) + cse_pkg::ext(t));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      coeff_count    <= CW'(MAX_COEFFS);
      domain_mid     <= '0;
      inv_half_width <= DW'(1) << cse_pkg::FRAC_BITS;
      cnt            <= '0;
      flag           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cse_pkg::REG_COEFF_COUNT:    coeff_count <= cfg_data[CW-1:0];
          cse_pkg::REG_DOMAIN_MID:     domain_mid <= cfg_data;
          cse_pkg::REG_INV_HALF_WIDTH: inv_half_width <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_FACC) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take && op == cse_pkg::OP_EVAL) begin
            pt    <= point;
            flag  <= 1'b0;
            cnt   <= '0;
            state <= S_OFS;
          end
        end
        S_OFS: begin
          x     <= d.val;
          flag  <= flag | d.sat;
          cnt   <= cnt + CW'(1);
          state <= S_MAP;
        end
        S_MAP: begin
          c0    <= rdata;
          cnt   <= cnt + CW'(1);
          state <= S_RND;
        end
        S_RND: begin
          c1    <= rdata;
          x     <= mres.val;
          x2    <= d2.val;
          flag  <= flag | mres.sat | d2.sat;
          state <= (n_eff == CW'(2)) ? S_FMUL : S_LMUL;
        end
        S_LMUL: begin
          c1    <= d.val;
          t     <= c1;
          flag  <= flag | d.sat;
          cnt   <= cnt + CW'(1);
          state <= S_ACC;
        end
        S_ACC: begin
          c0    <= d.val;
          flag  <= flag | mres.sat | d.sat;
          state <= (cnt == n_eff) ? S_FMUL : S_LMUL;
        end
        S_FMUL: begin
          state <= S_FACC;
        end
        S_FACC: begin
          if (out_free) begin
            value     <= d.val;
            saturated <= flag | mres.sat | d.sat;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CSE_ASSERT_NEXT(a_eval_start, take && op == cse_pkg::OP_EVAL, state == S_OFS)
  `CSE_ASSERT_NOW(a_cnt_bound, state == S_LMUL || state == S_ACC, cnt <= n_eff)
  `CSE_ASSERT_NEXT(a_result, state == S_FACC && out_free, out_valid && state == S_IDLE)

endmodule

>>> tb/sv/chebyshev_series_eval_core_tb.sv
`timescale 1ns / 1ps

module chebyshev_series_eval_core_tb;

  localparam int NUM_COEFFS = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0100_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hFF00_0000;
  localparam logic [31:0] Q_HALF = 32'h0080_0000;
  localparam logic [31:0] Q_NEG_HALF = 32'hFF80_0000;
  localparam logic [31:0] Q_TWO = 32'h0200_0000;

  typedef struct packed {
    logic        sat;
    logic [31:0] value;
  } series_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic op;
  logic [3:0] coeff_index;
  logic signed [31:0] coeff_value;
  logic signed [31:0] point;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] value;
  logic saturated;

  chebyshev_series_eval_core #(
    .MAX_COEFFS(NUM_COEFFS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .coeff_index(coeff_index),
    .coeff_value(coeff_value),
    .point(point),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value(value),
    .saturated(saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [4:0] count_shadow;
  logic signed [31:0] mid_shadow;
  logic signed [31:0] ihw_shadow;
  logic signed [31:0] tbl_shadow [NUM_COEFFS];
  bit step_sat;

  series_result_t expected_series[$];

  bit idle_on;
  int hold_cycles;
  int err_count;
  int load_count;
  int eval_count;
  int checked_count;
  int write_count;
  int sat_count;

  function automatic longint clamp_q(input longint v);
    if (v > 64'sd2147483647) begin
      step_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      step_sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (cse_pkg::FRAC_BITS - 1));
    return clamp_q(p >>> cse_pkg::FRAC_BITS);
  endfunction

  function automatic series_result_t predict_series(input logic signed [31:0] pt);
    int n;
    int i;
    longint x;
    longint x2;
    longint c0;
    longint c1;
    longint t;
    longint v;
    series_result_t r;
    step_sat = 1'b0;
    n = int'(count_shadow);
    if (n < 2) n = 2;
    if (n > NUM_COEFFS) n = NUM_COEFFS;
    x = clamp_q(longint'(pt) - longint'(mid_shadow));
    x = qmul(x, longint'(ihw_shadow));
    x2 = clamp_q(x * 2);
    c0 = longint'(tbl_shadow[0]);
    c1 = longint'(tbl_shadow[1]);
    for (i = 2; i < n; i++) begin
      t = c1;
      c1 = clamp_q(longint'(tbl_shadow[i]) - c0);
      c0 = clamp_q(qmul(c0, x2) + t);
    end
    v = clamp_q(c1 + qmul(c0, x));
    r.value = v[31:0];
    r.sat = step_sat;
    return r;
  endfunction

  function automatic logic [31:0] pick_q();
    int v;
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom_range(0, 1) ? Q_ONE : 32'h0;
      3: return $urandom;
      4, 5: begin
        v = int'($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
        return v;
      end
      default: begin
        v = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        return v;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp);
    err_count++;
  endtask

  task automatic send_req(input logic o, input logic [3:0] idx,
                          input logic [31:0] cv, input logic [31:0] pt);
    in_valid <= 1'b1;
    op <= o;
    coeff_index <= idx;
    coeff_value <= cv;
    point <= pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (o == cse_pkg::OP_EVAL) begin
      expected_series.push_back(predict_series(pt));
      eval_count++;
    end else begin
      tbl_shadow[idx] = cv;
      load_count++;
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    drop_input();
    while (expected_series.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    write_count++;
    case (idx)
      cse_pkg::REG_COEFF_COUNT: count_shadow = data[4:0];
      cse_pkg::REG_DOMAIN_MID: mid_shadow = data;
      cse_pkg::REG_INV_HALF_WIDTH: ihw_shadow = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] cnt, input logic [31:0] mid,
                            input logic [31:0] ihw);
    wait_idle();
    write_reg(cse_pkg::REG_COEFF_COUNT, cnt);
    write_reg(cse_pkg::REG_DOMAIN_MID, mid);
    write_reg(cse_pkg::REG_INV_HALF_WIDTH, ihw);
  endtask

  task automatic send_random(input int items);
    int k;
    for (k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) < 3)
        send_req(cse_pkg::OP_LOAD, 4'($urandom_range(0, NUM_COEFFS - 1)), pick_q(),
                 $urandom);
      else
        send_req(cse_pkg::OP_EVAL, 4'($urandom), $urandom, pick_q());
    end
    drop_input();
  endtask

  task automatic test_fill_table();
    int k;
    send_req(cse_pkg::OP_LOAD, 4'd0, Q_MAX, Q_MIN);
    send_req(cse_pkg::OP_LOAD, 4'd1, Q_MIN, Q_MAX);
    send_req(cse_pkg::OP_LOAD, 4'd2, 32'h0, 32'h0);
    send_req(cse_pkg::OP_LOAD, 4'd3, Q_ONE, 32'h0);
    send_req(cse_pkg::OP_LOAD, 4'd4, Q_NEG_ONE, 32'h0);
    for (k = 5; k < NUM_COEFFS; k++)
      send_req(cse_pkg::OP_LOAD, 4'(k), pick_q(), $urandom);
    drop_input();
  endtask

  task automatic test_directed_eval();
    send_req(cse_pkg::OP_EVAL, 4'hF, Q_MAX, 32'h0);
    send_req(cse_pkg::OP_EVAL, 4'h0, Q_MIN, Q_MAX);
    send_req(cse_pkg::OP_EVAL, 4'h0, 32'h0, Q_MIN);
    send_req(cse_pkg::OP_EVAL, 4'h5, 32'h0, Q_ONE);
    send_req(cse_pkg::OP_EVAL, 4'hA, 32'h0, Q_NEG_ONE);
    send_req(cse_pkg::OP_EVAL, 4'h0, 32'h0, Q_HALF);
    send_req(cse_pkg::OP_EVAL, 4'h0, 32'h0, Q_NEG_HALF);
    send_req(cse_pkg::OP_EVAL, 4'h0, 32'h0, 32'h0000_0001);
    drop_input();
  endtask

  task automatic test_config_sweep();
    set_config(32'd2, 32'h0, Q_ONE);
    send_random(50);
    set_config(32'd16, 32'h0, Q_ONE);
    send_random(50);
    set_config(32'd0, Q_MAX, Q_MIN);
    write_reg(REG_SPARE, $urandom);
    send_random(50);
    set_config(32'd1, Q_MIN, Q_MAX);
    send_random(50);
    set_config(32'd17, 32'h0, 32'h0);
    send_random(50);
    set_config(32'hFFFF_FFFF, Q_ONE, Q_HALF);
    send_random(50);
    set_config(32'd9, Q_NEG_HALF, Q_TWO);
    send_random(50);
  endtask

  task automatic test_backpressure();
    int k;
    set_config(32'd16, 32'h0, Q_HALF);
    hold_cycles = 300;
    for (k = 0; k < 12; k++)
      send_req(cse_pkg::OP_EVAL, 4'h0, 32'h0, pick_q());
    drop_input();
  endtask

  task automatic test_random_phases();
    int ph;
    logic [31:0] cnt;
    for (ph = 0; ph < 10; ph++) begin
      cnt = {$urandom_range(0, 1) ? 27'($urandom) : 27'h0,
             $urandom_range(0, 4) == 0 ? 5'($urandom) : 5'($urandom_range(2, 16))};
      set_config(cnt, pick_q(), pick_q());
      idle_on = $urandom_range(0, 3) != 0;
      send_random(100);
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    set_config(32'd16, pick_q(), pick_q());
    send_random(75);
    set_config(32'd5, 32'h0, Q_ONE);
    send_random(75);
  endtask

  always @(posedge clk) begin
    series_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_series.size() == 0) begin
        report_mismatch("result with no request pending", value, 32'h0);
      end else begin
        exp_r = expected_series.pop_front();
        checked_count++;
        if (exp_r.sat) sat_count++;
        if (value !== exp_r.value) report_mismatch("value", value, exp_r.value);
        if (saturated !== exp_r.sat)
          report_mismatch("saturated", 32'(saturated), 32'(exp_r.sat));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_series.size());
    $display("chebyshev_series_eval_core_tb NOT OK");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= cse_pkg::REG_COEFF_COUNT;
    cfg_data <= 32'h0;
    in_valid <= 1'b0;
    op <= cse_pkg::OP_LOAD;
    coeff_index <= 4'h0;
    coeff_value <= 32'h0;
    point <= 32'h0;
    out_stall <= 1'b0;
    count_shadow = 5'd16;
    mid_shadow = 32'h0;
    ihw_shadow = Q_ONE;
    foreach (tbl_shadow[k]) tbl_shadow[k] = 32'h0;
    idle_on = 1'b1;
    hold_cycles = 0;
    err_count = 0;
    load_count = 0;
    eval_count = 0;
    checked_count = 0;
    write_count = 0;
    sat_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_table();
    test_directed_eval();
    test_config_sweep();
    test_backpressure();
    test_random_phases();
    test_no_idle();

    wait_idle();
    $display("covered %0d coefficient loads and %0d evaluations over %0d register writes",
             load_count, eval_count, write_count);
    $display("checked %0d results, %0d of them saturated", checked_count, sat_count);
    if (err_count == 0 && expected_series.size() == 0) begin
      $display("chebyshev_series_eval_core_tb OK");
    end else begin
      $display("chebyshev_series_eval_core_tb NOT OK");
    end
    $finish;
  end

endmodule
